>>> rtl/fwcd_pkg.sv
// Shared types, constants and layout tables for the coordinate field decoder.
package fwcd_pkg;

  localparam int CHAR_W = 8;
  localparam int MODE_W = 2;
  localparam int POS_W  = 4;
  localparam int ACC_W  = 17;
  localparam int TOT_W  = 29;
  localparam int VAL_W  = 30;
  localparam int WGT_W  = 19;

  // field layouts
  localparam logic [MODE_W-1:0] MODE_LAT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LON  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MVAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ELEV = 2'd3;

  // characters of interest
  localparam logic [CHAR_W-1:0] CH_NORTH = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_EAST  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // character classes
  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // weight selectors
  localparam logic [2:0] WS_NONE   = 3'd0;
  localparam logic [2:0] WS_DEG_LL = 3'd1;  // degree, lat/lon
  localparam logic [2:0] WS_MIN_LL = 3'd2;  // minute, lat/lon
  localparam logic [2:0] WS_SEC    = 3'd3;
  localparam logic [2:0] WS_UNIT   = 3'd4;
  localparam logic [2:0] WS_DEG_MV = 3'd5;  // degree, magvar
  localparam logic [2:0] WS_MIN_MV = 3'd6;  // minute, magvar

  // classified character, front to back
  typedef struct packed {
    logic             digit_en;
    logic [1:0]       kind;
    logic [3:0]       dval;
    logic             commit;
    logic [2:0]       wsel;
    logic             last;
    logic             neg;
    logic             short_fld;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             short_fld;
  } res_t;

  function automatic logic [2:0] weight_sel(input logic [MODE_W-1:0] m,
                                            input logic [POS_W-1:0] p);
    logic [2:0] ws;
    ws = WS_NONE;
    case (m)
      MODE_LAT: begin
        case (p)
          4'd1, 4'd2: ws = WS_DEG_LL;
          4'd3, 4'd4: ws = WS_MIN_LL;
          4'd5, 4'd6: ws = WS_SEC;
          4'd7, 4'd8: ws = WS_UNIT;
          default:    ws = WS_NONE;
        endcase
      end
      MODE_LON: begin
        case (p)
          4'd1, 4'd2, 4'd3: ws = WS_DEG_LL;
          4'd4, 4'd5:       ws = WS_MIN_LL;
          4'd6, 4'd7:       ws = WS_SEC;
          4'd8, 4'd9:       ws = WS_UNIT;
          default:          ws = WS_NONE;
        endcase
      end
      MODE_MVAR: begin
        case (p)
          4'd1, 4'd2, 4'd3: ws = WS_DEG_MV;
          4'd4, 4'd5:       ws = WS_MIN_MV;
          4'd6:             ws = WS_UNIT;
          default:          ws = WS_NONE;
        endcase
      end
      default: begin
        case (p)
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ws = WS_UNIT;
          default:                      ws = WS_NONE;
        endcase
      end
    endcase
    return ws;
  endfunction

  function automatic logic subfield_end(input logic [MODE_W-1:0] m,
                                        input logic [POS_W-1:0] p);
    logic e;
    case (m)
      MODE_LAT:  e = (p == 4'd2) || (p == 4'd4) || (p == 4'd6) || (p == 4'd8);
      MODE_LON:  e = (p == 4'd3) || (p == 4'd5) || (p == 4'd7) || (p == 4'd9);
      MODE_MVAR: e = (p == 4'd3) || (p == 4'd5) || (p == 4'd6);
      default:   e = (p == 4'd4);
    endcase
    return e;
  endfunction

  function automatic logic [POS_W-1:0] layout_len(input logic [MODE_W-1:0] m);
    logic [POS_W-1:0] n;
    case (m)
      MODE_LAT:  n = 4'd9;
      MODE_LON:  n = 4'd10;
      MODE_MVAR: n = 4'd7;
      default:   n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic logic [WGT_W-1:0] weight_val(input logic [2:0] ws);
    logic [WGT_W-1:0] w;
    case (ws)
      WS_DEG_LL: w = 19'd360000;
      WS_MIN_LL: w = 19'd6000;
      WS_SEC:    w = 19'd100;
      WS_UNIT:   w = 19'd1;
      WS_DEG_MV: w = 19'd600;
      WS_MIN_MV: w = 19'd10;
      default:   w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/fixed_width_coordinate_field_decoder.sv
// Top level of the fixed-width coordinate field decoder.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   input    | push / full      | in_char_code[7:0], in_mode[1:0], in_last
//   result   | empty / pop      | out_value[29:0] signed, out_short_field
//
// One character is taken per clock; a transfer can happen on every edge while
// the result side keeps popping. A result reaches the ports through the command
// queue, then the commit stage, whose weighted add is written into the result
// queue. One character a cycle unless full is raised.
// Reset (rst_n low, synchronous) clears position, layout, queues and totals.
// A stalled result side fills the result queue, commit stage and command queue, then raises full.
module fixed_width_coordinate_field_decoder import fwcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [CHAR_W-1:0]       in_char_code,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic                    in_last,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_short_field
);

  logic accept;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_empty;
  logic q_take;

  // input transfer
  assign accept = push && !full;

  // position tracking and classification
  fwcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .mode      (in_mode),
    .last      (in_last),
    .cmd       (front_cmd)
  );

  // decouples the front from back-end stalls
  fwcd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (back_cmd),
    .empty   (q_empty)
  );

  // accumulation, weighting, sign and result queue
  fwcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (!q_empty),
    .cmd_take  (q_take),
    .res_empty (empty),
    .res_pop   (pop),
    .res_value (out_value),
    .res_short (out_short_field)
  );

endmodule

>>> rtl/fwcd_front.sv
// Front end: character position, layout latch, sign and character classification.
module fwcd_front import fwcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [MODE_W-1:0] mode,
  input  logic              last,
  output cmd_t              cmd
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              neg_r, neg_nxt;

  logic              first;
  logic [MODE_W-1:0] m;
  logic              is_digit;
  logic              neg_cur;
  logic              digit_pos;
  logic [2:0]        ws;

  always_comb begin
    first    = (pos_r == '0);
    m        = first ? mode : mode_r;
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    neg_cur = neg_r;
    if (first) begin
      case (m)
        MODE_LAT:  neg_cur = (char_code != CH_NORTH);
        MODE_LON,
        MODE_MVAR: neg_cur = (char_code != CH_EAST);
        default:   neg_cur = (char_code == CH_MINUS);
      endcase
    end

    // hemisphere letter or elevation minus sign is not a digit position
    digit_pos = !(first && ((m != MODE_ELEV) || (char_code == CH_MINUS)));
    ws        = weight_sel(m, pos_r);

    cmd.digit_en  = digit_pos && (ws != WS_NONE);
    cmd.kind      = is_digit ? KIND_DIGIT :
                    (char_code == CH_SPACE) ? KIND_SPACE : KIND_OTHER;
    cmd.dval      = char_code[3:0];
    cmd.commit    = (ws != WS_NONE) && (subfield_end(m, pos_r) || last);
    cmd.wsel      = ws;
    cmd.last      = last;
    cmd.neg       = neg_cur;
    cmd.short_fld = ({1'b0, pos_r} + 5'd1) < {1'b0, layout_len(m)};

    pos_nxt  = pos_r;
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    if (accept) begin
      mode_nxt = m;
      neg_nxt  = neg_cur;
      if (last) begin
        pos_nxt = '0;
      end else if (pos_r != '1) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= MODE_LAT;
      neg_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      neg_r  <= neg_nxt;
    end
  end

endmodule

>>> rtl/fwcd_cmd_queue.sv
// Two-entry queue of classified characters between front and back.
module fwcd_cmd_queue import fwcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == 2'd2);
    empty      = (count_r == 2'd0);
    rd_data    = entries_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/fwcd_back.sv
// Back end: subfield accumulation, weighted total, signing and result queue.
module fwcd_back import fwcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic                    cmd_valid,
  output logic                    cmd_take,
  output logic                    res_empty,
  input  logic                    res_pop,
  output logic signed [VAL_W-1:0] res_value,
  output logic                    res_short
);

  // accumulate stage
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             started_r, started_nxt;
  logic             stopped_r, stopped_nxt;
  logic [ACC_W-1:0] acc_upd;
  logic             started_upd, stopped_upd;

  // commit stage: one finished subfield waiting to be weighted
  logic             p_valid_r, p_valid_nxt;
  logic [ACC_W-1:0] p_acc_r;
  logic [2:0]       p_wsel_r;
  logic             p_last_r, p_neg_r, p_short_r;
  logic             p_retire;
  logic             p_load;

  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [TOT_W-1:0]       total_sum;
  logic [ACC_W+WGT_W-1:0] product;
  logic [VAL_W-1:0]       signed_val;

  // result queue
  res_t       res_r [2];
  logic       rw_ptr_r, rr_ptr_r;
  logic [1:0] rcount_r, rcount_nxt;
  logic       res_full, res_push, res_take;

  always_comb begin
    res_full  = (rcount_r == 2'd2);
    res_empty = (rcount_r == 2'd0);
    res_take  = res_pop && !res_empty;

    p_retire = p_valid_r && (!p_last_r || !res_full);
    cmd_take = cmd_valid && (!p_valid_r || p_retire);
    p_load   = cmd_take && (cmd.commit || cmd.last);

    acc_upd     = acc_r;
    started_upd = started_r;
    stopped_upd = stopped_r;
    if (cmd.digit_en && !stopped_r) begin
      case (cmd.kind)
        KIND_DIGIT: begin
          acc_upd     = ACC_W'({acc_r, 3'b000} + {acc_r, 1'b0} + {{(ACC_W-1){1'b0}}, cmd.dval});
          started_upd = 1'b1;
        end
        KIND_SPACE: begin
          stopped_upd = started_r;   // leading spaces skipped
        end
        default: begin
          stopped_upd = 1'b1;
        end
      endcase
    end

    acc_nxt     = acc_r;
    started_nxt = started_r;
    stopped_nxt = stopped_r;
    if (cmd_take) begin
      if (cmd.commit || cmd.last) begin
        acc_nxt     = '0;
        started_nxt = 1'b0;
        stopped_nxt = 1'b0;
      end else begin
        acc_nxt     = acc_upd;
        started_nxt = started_upd;
        stopped_nxt = stopped_upd;
      end
    end

    p_valid_nxt = cmd_take ? p_load : (p_valid_r && !p_retire);

    product    = p_acc_r * weight_val(p_wsel_r);
    total_sum  = total_r + product[TOT_W-1:0];
    signed_val = p_neg_r ? (VAL_W'(0) - {1'b0, total_sum}) : {1'b0, total_sum};
    res_push   = p_retire && p_last_r;

    total_nxt = total_r;
    if (p_retire) begin
      total_nxt = p_last_r ? '0 : total_sum;
    end

    rcount_nxt = rcount_r + {1'b0, res_push} - {1'b0, res_take};

    res_value = res_r[rr_ptr_r].value;
    res_short = res_r[rr_ptr_r].short_fld;
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_acc_r   <= acc_upd;
      p_wsel_r  <= cmd.commit ? cmd.wsel : WS_NONE;
      p_last_r  <= cmd.last;
      p_neg_r   <= cmd.neg;
      p_short_r <= cmd.short_fld;
    end
    if (res_push) begin
      res_r[rw_ptr_r] <= '{value: signed_val, short_fld: p_short_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      started_r <= 1'b0;
      stopped_r <= 1'b0;
      p_valid_r <= 1'b0;
      total_r   <= '0;
      rw_ptr_r  <= 1'b0;
      rr_ptr_r  <= 1'b0;
      rcount_r  <= '0;
    end else begin
      acc_r     <= acc_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
      p_valid_r <= p_valid_nxt;
      total_r   <= total_nxt;
      rw_ptr_r  <= rw_ptr_r ^ res_push;
      rr_ptr_r  <= rr_ptr_r ^ res_take;
      rcount_r  <= rcount_nxt;
    end
  end

endmodule
